// ===== rtl/core/task_scheduler_with_semaphores_assert.svh =====
// ---------------------------------------------------------------------------
// Task scheduler assertion macros
// Shared concurrent assertion forms, clocked on the rising edge, held off
// during reset.
// ---------------------------------------------------------------------------
`ifndef TASK_SCHEDULER_WITH_SEMAPHORES_ASSERT_SVH
`define TASK_SCHEDULER_WITH_SEMAPHORES_ASSERT_SVH

// Property holds at every edge out of reset.
`define TSWS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TSWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tsws_pkg.sv =====
// ---------------------------------------------------------------------------
// tsws_pkg
// Command codes, status codes, FSM encoding and the controller/datapath
// interface types of the task scheduler.
// ---------------------------------------------------------------------------
package tsws_pkg;

	localparam logic [3:0] KIND_CREATE   = 4'd0;
	localparam logic [3:0] KIND_DELETE   = 4'd1;
	localparam logic [3:0] KIND_SCHEDULE = 4'd2;
	localparam logic [3:0] KIND_RESET    = 4'd3;
	localparam logic [3:0] KIND_COMPLETE = 4'd4;
	localparam logic [3:0] KIND_DELAY    = 4'd5;
	localparam logic [3:0] KIND_GIVE     = 4'd6;
	localparam logic [3:0] KIND_TAKE     = 4'd7;
	localparam logic [3:0] KIND_START    = 4'd8;
	localparam logic [3:0] KIND_RETRY    = 4'd9;

	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_IGNORED  = 3'd1;
	localparam logic [2:0] STAT_FULL     = 3'd2;
	localparam logic [2:0] STAT_UNKNOWN  = 3'd3;
	localparam logic [2:0] STAT_NOSTART  = 3'd4;

	localparam logic [7:0]  START_ID  = 8'hFF;
	localparam logic [31:0] NO_BEST   = 32'h8000_0000;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PREP = 6'b000010,
		ST_LOOK = 6'b000100,
		ST_ACT  = 6'b001000,
		ST_SEL  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	typedef struct packed {
		logic capture;
		logic prep;
		logic look;
		logic act;
		logic sel;
		logic load;
	} ctl_cmd_t;

	typedef struct packed {
		logic need_look;
		logic look_done;
		logic need_sel;
		logic sel_done;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/core/tsws_ctrl.sv =====
// ---------------------------------------------------------------------------
// tsws_ctrl
// Command sequencer: capture, setup, optional lookup scan, state update,
// optional selection scan, result hand-off.
// ---------------------------------------------------------------------------
module tsws_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tsws_pkg::dp_stat_t stat,
	output tsws_pkg::ctl_cmd_t cmd
);
	import tsws_pkg::*;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = stat.need_look ? ST_LOOK : ST_ACT;
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				if (stat.look_done) state_d = ST_ACT;
			end
			ST_ACT: begin
				cmd.act = 1'b1;
				state_d = stat.need_sel ? ST_SEL : ST_FIN;
			end
			ST_SEL: begin
				cmd.sel = 1'b1;
				if (stat.sel_done) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/tsws_dp.sv =====
// ---------------------------------------------------------------------------
// tsws_dp
// Task table, semaphores, shared scan pipeline and result register.
// ---------------------------------------------------------------------------
module tsws_dp #(
	parameter int MAX_TASKS = 8,
	parameter int SEM_COUNT = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tsws_pkg::ctl_cmd_t cmd,
	output tsws_pkg::dp_stat_t stat,
	input  logic [3:0]         in_kind,
	input  logic [7:0]         in_task_id,
	input  logic [31:0]        in_duration,
	input  logic [7:0]         in_sem_id,
	input  logic [31:0]        in_now_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         out_status,
	output logic               out_rescheduled,
	output logic               out_none_ready,
	output logic               out_switched,
	output logic [7:0]         out_running_id,
	output logic [30:0]        out_wait_ms
);
	import tsws_pkg::*;

	localparam int IW = $clog2(MAX_TASKS);
	localparam int UW = $clog2(MAX_TASKS + 1);
	localparam int SW = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
	localparam logic [UW-1:0] MAX_U   = UW'(MAX_TASKS);
	localparam logic [8:0]    SEM_LIM = 9'(SEM_COUNT);

	// captured command
	logic [3:0]  kind_q;
	logic [7:0]  tid_q;
	logic [31:0] dur_q;
	logic [7:0]  sem_q;
	logic [31:0] now_q;

	// task state
	logic [MAX_TASKS-1:0] ready_q;
	logic [UW-1:0]        used_q;
	logic [IW-1:0]        running_q;
	logic                 started_q;
	logic [7:0]           running_id_q;
	logic [7:0]           id_mem  [MAX_TASKS];
	logic [31:0]          wake_mem[MAX_TASKS];
	logic [7:0]           id_rd_q;
	logic [31:0]          wake_rd_q;

	// semaphores
	logic [SEM_COUNT-1:0] sem_full_q;
	logic [SEM_COUNT-1:0] sem_wait_q;
	logic [IW-1:0]        waiter_mem[SEM_COUNT];
	logic [IW-1:0]        waiter_rd_q;

	// scan pipeline
	logic [UW-1:0] cnt_q;
	logic [IW-1:0] cur_q;
	logic [IW-1:0] raddr;
	logic          v_s1;
	logic [IW-1:0] slot_s1;
	logic          found_q;
	logic [IW-1:0] fslot_q;
	logic [31:0]   best_time_q;
	logic [IW-1:0] best_slot_q;
	logic [7:0]    best_id_q;

	// per-command results
	logic [2:0] status_q;
	logic       resched_q;
	logic       sw_act_q;

	logic          sem_ok;
	logic [SW-1:0] sem_idx;
	logic [7:0]    key;
	logic          need_sel;
	logic [2:0]    status_d;
	logic          scan_go;
	logic [IW-1:0] last_slot;
	logic [31:0]   delta;
	logic [31:0]   delta_c;
	logic          none_d;
	logic          sw_d;
	logic [31:0]   sum_now;

	logic          wk_we;
	logic [IW-1:0] wk_addr;
	logic [31:0]   wk_data;

	assign sem_ok    = {1'b0, sem_q} < SEM_LIM;
	assign sem_idx   = SW'(sem_q);
	assign key       = (kind_q == KIND_START) ? START_ID : tid_q;
	assign scan_go   = cmd.look || cmd.sel;
	assign last_slot = IW'(used_q - UW'(1));
	assign raddr     = cmd.sel ? cur_q : IW'(cnt_q);
	assign sum_now   = now_q + dur_q;
	assign delta     = wake_rd_q - now_q;
	assign delta_c   = delta[31] ? 32'd0 : delta;

	assign stat.need_look = (kind_q == KIND_CREATE) || (kind_q == KIND_DELETE) ||
	                        (kind_q == KIND_SCHEDULE) || (kind_q == KIND_START);
	assign stat.look_done = (cnt_q == used_q) && !v_s1;
	assign stat.sel_done  = (cnt_q == used_q) && !v_s1;
	assign stat.need_sel  = need_sel;
	assign stat.out_free  = !out_valid || out_ready;

	// decide status, selection and wake write for the action step
	always_comb begin
		need_sel = 1'b0;
		status_d = STAT_OK;
		wk_we    = 1'b0;
		wk_addr  = fslot_q;
		wk_data  = sum_now;
		case (kind_q)
			KIND_CREATE: begin
				if (found_q) status_d = STAT_IGNORED;
				else if (used_q >= MAX_U) status_d = STAT_FULL;
				else begin
					wk_we   = 1'b1;
					wk_addr = IW'(used_q);
					wk_data = 32'd0;
				end
			end
			KIND_DELETE: begin
				if (!found_q) status_d = STAT_UNKNOWN;
				else need_sel = started_q && (fslot_q == running_q);
			end
			KIND_SCHEDULE: begin
				if (!found_q) status_d = STAT_UNKNOWN;
				else wk_we = 1'b1;
			end
			KIND_RESET: status_d = STAT_OK;
			KIND_COMPLETE, KIND_RETRY: begin
				if (!started_q) status_d = STAT_NOSTART;
				else need_sel = 1'b1;
			end
			KIND_DELAY: begin
				if (!started_q) status_d = STAT_NOSTART;
				else begin
					need_sel = 1'b1;
					wk_we    = 1'b1;
					wk_addr  = running_q;
				end
			end
			KIND_GIVE: begin
				if (!sem_ok) status_d = STAT_IGNORED;
				else if (!sem_full_q[sem_idx] && sem_wait_q[sem_idx]) begin
					wk_we   = 1'b1;
					wk_addr = waiter_rd_q;
					wk_data = now_q;
				end
			end
			KIND_TAKE: begin
				if (!sem_ok) status_d = STAT_IGNORED;
				else if (!sem_full_q[sem_idx]) begin
					if (!started_q) status_d = STAT_NOSTART;
					else need_sel = 1'b1;
				end
			end
			KIND_START: begin
				if (!found_q) status_d = STAT_UNKNOWN;
			end
			default: status_d = STAT_IGNORED;
		endcase
	end

	// memories: one write, registered read
	always_ff @(posedge clk) begin
		if (cmd.act && kind_q == KIND_CREATE && status_d == STAT_OK)
			id_mem[IW'(used_q)] <= tid_q;
		if (cmd.act && wk_we)
			wake_mem[wk_addr] <= wk_data;
		id_rd_q   <= id_mem[raddr];
		wake_rd_q <= wake_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.act && kind_q == KIND_TAKE && status_d == STAT_OK && need_sel)
			waiter_mem[sem_idx] <= running_q;
		waiter_rd_q <= waiter_mem[sem_idx];
	end

	// command capture and scan bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= in_kind;
			tid_q  <= in_task_id;
			dur_q  <= in_duration;
			sem_q  <= in_sem_id;
			now_q  <= in_now_ms;
		end
		if (scan_go) slot_s1 <= raddr;
		if (cmd.prep) found_q <= 1'b0;
		else if (cmd.look && v_s1 && id_rd_q == key) begin
			found_q <= 1'b1;
			fslot_q <= slot_s1;
		end
		if (cmd.act) begin
			best_time_q <= NO_BEST;
			cur_q       <= (running_q == '0) ? last_slot : IW'(running_q - IW'(1));
			status_q    <= status_d;
			resched_q   <= need_sel;
			sw_act_q    <= (kind_q == KIND_START) && found_q &&
			               (!started_q || fslot_q != running_q);
		end else if (cmd.sel) begin
			if (cnt_q < used_q)
				cur_q <= (cur_q == '0) ? last_slot : IW'(cur_q - IW'(1));
			if (v_s1 && ready_q[slot_s1] && delta_c < best_time_q) begin
				best_time_q <= delta_c;
				best_slot_q <= slot_s1;
				best_id_q   <= id_rd_q;
			end
		end
	end

	assign none_d = resched_q && best_time_q[31];
	assign sw_d   = resched_q ? (!none_d && best_slot_q != running_q) : sw_act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			v_s1       <= 1'b0;
			ready_q    <= '0;
			used_q     <= '0;
			running_q  <= '0;
			started_q  <= 1'b0;
			sem_full_q <= '0;
			sem_wait_q <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (cmd.prep || cmd.act) begin
				cnt_q <= '0;
				v_s1  <= 1'b0;
			end else if (scan_go) begin
				v_s1 <= (cnt_q < used_q);
				if (cnt_q < used_q) cnt_q <= cnt_q + UW'(1);
			end

			if (cmd.act && status_d == STAT_OK) begin
				case (kind_q)
					KIND_CREATE: begin
						ready_q[IW'(used_q)] <= 1'b0;
						used_q               <= used_q + UW'(1);
					end
					KIND_DELETE:   ready_q[fslot_q] <= 1'b0;
					KIND_SCHEDULE: ready_q[fslot_q] <= 1'b1;
					KIND_RESET: begin
						ready_q <= started_q ?
						           (ready_q & (MAX_TASKS'(1) << running_q)) : '0;
					end
					KIND_COMPLETE: ready_q[running_q] <= 1'b0;
					KIND_GIVE: begin
						if (!sem_full_q[sem_idx]) begin
							if (sem_wait_q[sem_idx]) begin
								ready_q[waiter_rd_q]  <= 1'b1;
								sem_wait_q[sem_idx]   <= 1'b0;
							end else begin
								sem_full_q[sem_idx] <= 1'b1;
							end
						end
					end
					KIND_TAKE: begin
						if (sem_full_q[sem_idx]) sem_full_q[sem_idx] <= 1'b0;
						else begin
							sem_wait_q[sem_idx] <= 1'b1;
							ready_q[running_q]  <= 1'b0;
						end
					end
					KIND_START: begin
						running_q <= fslot_q;
						started_q <= 1'b1;
					end
					default: ready_q <= ready_q;
				endcase
			end

			if (cmd.load) begin
				out_valid <= 1'b1;
				if (resched_q && !none_d) running_q <= best_slot_q;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// running id tracks the running slot's identifier
	always_ff @(posedge clk) begin
		if (cmd.act && kind_q == KIND_START && status_d == STAT_OK)
			running_id_q <= START_ID;
		else if (cmd.load && resched_q && !none_d)
			running_id_q <= best_id_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_status      <= status_q;
			out_rescheduled <= resched_q;
			out_none_ready  <= none_d;
			out_switched    <= sw_d;
			out_running_id  <= !started_q ? 8'd0 :
			                   ((resched_q && !none_d) ? best_id_q : running_id_q);
			out_wait_ms     <= best_time_q[30:0];
		end
	end

endmodule

// ===== rtl/core/task_scheduler_with_semaphores.sv =====
// ---------------------------------------------------------------------------
// task_scheduler_with_semaphores
// Cooperative task table and scheduler with single-waiter binary semaphores.
// ---------------------------------------------------------------------------
//  channel | dir | tvalid/tready | tdata                            | tuser
//  s_      | in  | command item  | task_id, duration, sem_id, now_ms| kind
//  m_      | out | result item   | rescheduled..wait_ms             | status
//
// One command is in flight at a time. An item passes through capture, setup,
// id lookup (create, delete, schedule, start only), state update, selection
// (selecting commands only) and result load; both scans cover the n created
// tasks, and only a delete of the running task needs both scans. The single read
// port of the task memories sets the one-slot-per-cycle scans.
// Reset clears the table and semaphores at once; no clearing pass. A result
// waits in the output register while the next item is taken; the block stalls
// only in its final state when that register is still full.
// ---------------------------------------------------------------------------
`include "task_scheduler_with_semaphores_assert.svh"

module task_scheduler_with_semaphores #(
	parameter int MAX_TASKS = 8,
	parameter int SEM_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // task_id[7:0], duration[39:8], sem_id[47:40], now_ms[79:48]
	input  logic [3:0]  s_tuser,   // kind[3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // rescheduled[0], none_ready[1], switched[2],
	                               // running_id[10:3], wait_ms[41:11], zero[47:42]
	output logic [2:0]  m_tuser    // status[2:0]
);
	import tsws_pkg::*;

	ctl_cmd_t   cmd;
	dp_stat_t   stat;
	logic       rescheduled;
	logic       none_ready;
	logic       switched;
	logic [7:0] running_id;
	logic [30:0] wait_ms;

	// sequence each command
	tsws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// table, semaphores, scans and result register
	tsws_dp #(
		.MAX_TASKS (MAX_TASKS),
		.SEM_COUNT (SEM_COUNT)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.in_kind         (s_tuser),
		.in_task_id      (s_tdata[7:0]),
		.in_duration     (s_tdata[39:8]),
		.in_sem_id       (s_tdata[47:40]),
		.in_now_ms       (s_tdata[79:48]),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_status      (m_tuser),
		.out_rescheduled (rescheduled),
		.out_none_ready  (none_ready),
		.out_switched    (switched),
		.out_running_id  (running_id),
		.out_wait_ms     (wait_ms)
	);

	// pack result fields, pad to whole bytes
	assign m_tdata = {6'd0, wait_ms, running_id, switched, none_ready, rescheduled};

	// hold off a second command until the first one's result is loaded
	`TSWS_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready, "second item accepted while busy")
	`TSWS_ASSERT(a_status_range, clk, arst_n, !m_tvalid || m_tuser <= STAT_NOSTART, "status code out of range")
	`TSWS_ASSERT(a_none_implies_sel, clk, arst_n, !(m_tvalid && none_ready) || (rescheduled && wait_ms == 31'd0 && !switched), "none_ready without selection")
	`TSWS_ASSERT(a_sel_status_ok, clk, arst_n, !(m_tvalid && rescheduled) || m_tuser == STAT_OK, "selection with error status")

endmodule
